// ===== hdl/vigenere_cipher_stream_macros.svh =====
`ifndef VIGENERE_CIPHER_STREAM_MACROS_SVH
`define VIGENERE_CIPHER_STREAM_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define VCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/vcs_pkg.sv =====
package vcs_pkg;

    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned KLEN_W     = 4;
    localparam int unsigned ALPHA_W    = 5;

    localparam logic [CHAR_W-1:0]     CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0]     LOWER_A      = 8'h61;
    localparam logic [CHAR_W-1:0]     LOWER_Z      = 8'h7A;
    localparam logic [CHAR_W-1:0]     UPPER_A      = 8'h41;
    localparam logic [CHAR_W-1:0]     UPPER_Z      = 8'h5A;
    localparam logic [ALPHA_W:0]      ALPHA_SIZE   = 6'd26;
    localparam logic [CFG_DATA_W-1:0] KEY_RESET    = 64'd97;
    localparam logic [KLEN_W-1:0]     KLEN_RESET   = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIRECTION  = 2'd0,
        REG_KEY_CHARS  = 2'd1,
        REG_KEY_LENGTH = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic done;
        logic slot_free;
    } dp_status_t;

    function automatic logic is_lower(input logic [CHAR_W-1:0] c);
        return (c >= LOWER_A) && (c <= LOWER_Z);
    endfunction

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= UPPER_A) && (c <= UPPER_Z);
    endfunction

    // Letter position 0..25; meaningful only for letters.
    function automatic logic [ALPHA_W-1:0] letter_index(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = is_lower(c) ? (c - LOWER_A) : (c - UPPER_A);
        return d[ALPHA_W-1:0];
    endfunction

endpackage

// ===== hdl/vcs_in_if.sv =====
interface vcs_in_if;
    logic                          valid;
    logic                          ready;
    logic [vcs_pkg::CHAR_W-1:0]    in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

// ===== hdl/vcs_out_if.sv =====
interface vcs_out_if;
    logic                          valid;
    logic                          ready;
    logic [vcs_pkg::CHAR_W-1:0]    out_char;
    logic                          key_error;

    modport source (output valid, output out_char, output key_error, input ready);
    modport sink   (input valid, input out_char, input key_error, output ready);
endinterface

// ===== hdl/vcs_cfg_if.sv =====
interface vcs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [vcs_pkg::CFG_IDX_W-1:0]     index;
    logic [vcs_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/vcs_ctrl.sv =====
module vcs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  vcs_pkg::dp_status_t    status,
    output vcs_pkg::ctrl_cmd_t     cmd
);

    vcs_pkg::state_t state_reg;
    vcs_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vcs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = vcs_pkg::ST_SCAN;
                end
            end
            vcs_pkg::ST_SCAN:
            begin
                if (status.slot_free && status.done)
                begin
                    state_next = vcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            vcs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            vcs_pkg::ST_SCAN:
            begin
                // scan stalls while a finished beat still sits unclaimed
                cmd.step = status.slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vcs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/vcs_dp.sv =====
module vcs_dp #(
    parameter int unsigned KEY_CHARS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vcs_pkg::ctrl_cmd_t                  cmd,
    output vcs_pkg::dp_status_t                 status,
    input  logic                                cfg_valid,
    input  logic [vcs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vcs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [vcs_pkg::CHAR_W-1:0]          in_char,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [vcs_pkg::CHAR_W-1:0]          out_char,
    output logic                                key_error
);

    localparam int unsigned POS_W  = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
    localparam int unsigned LEN_W  = $clog2(KEY_CHARS + 1);
    localparam int unsigned CMP_W  = POS_W + 1;
    localparam int unsigned KEY_W  = KEY_CHARS * vcs_pkg::CHAR_W;
    localparam int unsigned AW     = vcs_pkg::ALPHA_W;

    logic                                       dir_reg,       dir_next;
    logic [KEY_CHARS-1:0][vcs_pkg::CHAR_W-1:0]  key_reg,       key_next;
    logic [vcs_pkg::KLEN_W-1:0]                 klen_reg,      klen_next;
    logic [POS_W-1:0]                           pos_reg,       pos_next;
    logic [POS_W-1:0]                           tries_reg,     tries_next;
    logic [vcs_pkg::CHAR_W-1:0]                 char_reg,      char_next;
    logic [vcs_pkg::CHAR_W-1:0]                 out_char_reg,  out_char_next;
    logic                                       key_err_reg,   key_err_next;
    logic                                       out_valid_reg, out_valid_next;

    logic [LEN_W-1:0]            act_len;
    logic [CMP_W-1:0]            len_x;
    logic [CMP_W-1:0]            pos_inc;
    logic [POS_W-1:0]            pos_wrap;
    logic                        last_try;
    logic [vcs_pkg::CHAR_W-1:0]  key_byte;
    logic                        key_letter;
    logic [AW-1:0]               shift;
    logic                        is_nl;
    logic                        c_lower;
    logic                        c_letter;
    logic [vcs_pkg::CHAR_W-1:0]  base;
    logic [AW-1:0]               c_idx;
    logic [AW:0]                 sum;
    logic [AW:0]                 res_idx;
    logic [vcs_pkg::CHAR_W-1:0]  res_char;
    logic                        done;
    logic                        slot_free;

    always_comb
    begin
        if (klen_reg == '0)
        begin
            act_len = LEN_W'(1);
        end
        else if (klen_reg > vcs_pkg::KLEN_W'(KEY_CHARS))
        begin
            act_len = LEN_W'(KEY_CHARS);
        end
        else
        begin
            act_len = klen_reg[LEN_W-1:0];
        end
    end

    assign len_x    = CMP_W'(act_len);
    assign pos_inc  = CMP_W'(pos_reg) + CMP_W'(1);
    assign pos_wrap = (pos_inc >= len_x) ? '0 : pos_inc[POS_W-1:0];
    assign last_try = (CMP_W'(tries_reg) + CMP_W'(1)) >= len_x;

    assign key_byte   = key_reg[pos_reg];
    assign key_letter = vcs_pkg::is_lower(key_byte) || vcs_pkg::is_upper(key_byte);
    assign shift      = vcs_pkg::letter_index(key_byte);

    assign is_nl    = (char_reg == vcs_pkg::CHAR_NEWLINE);
    assign c_lower  = vcs_pkg::is_lower(char_reg);
    assign c_letter = c_lower || vcs_pkg::is_upper(char_reg);
    assign base     = c_lower ? vcs_pkg::LOWER_A : vcs_pkg::UPPER_A;
    assign c_idx    = vcs_pkg::letter_index(char_reg);

    // mod 26 shift by one compare and correction
    always_comb
    begin
        if (dir_reg)
        begin
            if (c_idx >= shift)
            begin
                res_idx = {1'b0, c_idx} - {1'b0, shift};
            end
            else
            begin
                res_idx = {1'b0, c_idx} + vcs_pkg::ALPHA_SIZE - {1'b0, shift};
            end
            sum = '0;
        end
        else
        begin
            sum = {1'b0, c_idx} + {1'b0, shift};
            res_idx = (sum >= vcs_pkg::ALPHA_SIZE) ? (sum - vcs_pkg::ALPHA_SIZE) : sum;
        end
    end

    assign res_char  = c_letter ? (base + vcs_pkg::CHAR_W'(res_idx)) : char_reg;
    assign done      = is_nl || key_letter || last_try;
    assign slot_free = !out_valid_reg || out_ready;

    assign status.done      = done;
    assign status.slot_free = slot_free;

    always_comb
    begin
        dir_next       = dir_reg;
        key_next       = key_reg;
        klen_next      = klen_reg;
        pos_next       = pos_reg;
        tries_next     = tries_reg;
        char_next      = char_reg;
        out_char_next  = out_char_reg;
        key_err_next   = key_err_reg;
        out_valid_next = out_valid_reg;

        if (cfg_valid)
        begin
            case (vcs_pkg::cfg_reg_t'(cfg_index))
                vcs_pkg::REG_DIRECTION:  dir_next  = cfg_data[0];
                vcs_pkg::REG_KEY_CHARS:  key_next  = cfg_data[KEY_W-1:0];
                vcs_pkg::REG_KEY_LENGTH: klen_next = cfg_data[vcs_pkg::KLEN_W-1:0];
                default:                 dir_next  = dir_reg;
            endcase
        end

        if (cmd.load)
        begin
            char_next  = in_char;
            tries_next = '0;
            if ((in_char != vcs_pkg::CHAR_NEWLINE) && (CMP_W'(pos_reg) >= len_x))
            begin
                pos_next = '0;
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.step)
        begin
            if (!is_nl)
            begin
                // each probe, failed or not, moves on; after a full lap it is back at the start
                pos_next   = pos_wrap;
                tries_next = tries_reg + POS_W'(1);
            end
            if (done)
            begin
                out_valid_next = 1'b1;
                if (is_nl)
                begin
                    out_char_next = vcs_pkg::CHAR_NEWLINE;
                    key_err_next  = 1'b0;
                end
                else if (key_letter)
                begin
                    out_char_next = res_char;
                    key_err_next  = 1'b0;
                end
                else
                begin
                    out_char_next = '0;
                    key_err_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg       <= 1'b0;
            key_reg       <= KEY_W'(vcs_pkg::KEY_RESET);
            klen_reg      <= vcs_pkg::KLEN_RESET;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dir_reg       <= dir_next;
            key_reg       <= key_next;
            klen_reg      <= klen_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tries_reg    <= tries_next;
        char_reg     <= char_next;
        out_char_reg <= out_char_next;
        key_err_reg  <= key_err_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign key_error = key_err_reg;

endmodule

// ===== hdl/vigenere_cipher_stream.sv =====
// Vigenere stream cipher, one ASCII character per beat in, one per beat out. An item is taken
// in while the block is idle, then a key scan tests one key byte per cycle while the output
// register has room: a newline, or a character whose current key byte is a letter, ends the
// scan at its first step, the worst case steps through the whole active key length. Results
// sit in an output register, so the next character is taken while a result waits; the key
// scan holds for as long as that register is still full and resumes once the beat is taken.
// Configuration writes are always ready and must only be issued while the block is idle.
`include "vigenere_cipher_stream_macros.svh"

module vigenere_cipher_stream #(
    parameter int unsigned KEY_CHARS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    vcs_in_if.sink         in_ch,
    vcs_out_if.source      out_ch,
    vcs_cfg_if.sink        cfg
);

    vcs_pkg::ctrl_cmd_t   cmd;
    vcs_pkg::dp_status_t  status;

    assign cfg.ready = 1'b1;

    vcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    vcs_dp #(
        .KEY_CHARS (KEY_CHARS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .in_char   (in_ch.in_char),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_char  (out_ch.out_char),
        .key_error (out_ch.key_error)
    );

    `VCS_ASSERT_NOW(a_err_zero_char, out_ch.valid && out_ch.key_error, out_ch.out_char == '0, "key error beat with nonzero character")
    `VCS_ASSERT_NEXT(a_busy_after_take, in_ch.valid && in_ch.ready, !in_ch.ready, "input ready right after a take")
    `VCS_ASSERT_NEXT(a_done_gives_beat, cmd.step && status.done, out_ch.valid, "finished scan did not present a result")
    `VCS_ASSERT_NOW(a_step_needs_room, cmd.step, !out_ch.valid || out_ch.ready, "scan advanced over a stalled result")

endmodule
